### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/sia_pkg.sv
package sia_pkg;

	localparam int SIA_DEPTH = 32;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 6;
	localparam int RIDX_W    = 5;
	localparam int TOTAL_W   = 37;
	localparam int COUNT_W   = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 144;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_READ   = 1'b1
	} sia_action_t;

	typedef struct packed {
		logic                     en;
		logic signed [DATA_W-1:0] value;
	} sia_ins_t;

	typedef struct packed {
		logic occupied;
		logic tail;
	} sia_cell_stat_t;

endpackage

### hw/rtl/sorted_insert_array_top.sv
// Channel   Direction  tdata fields (low bit up)                              tuser
// s_axis    in         new_value[31:0] read_index[36:32] zero[39:37]          action
// m_axis    out        read_value[31:0] entry_count[37:32] smallest[69:38]    accepted
//                      largest[101:70] total[138:102] zero[143:139]
// cfg       in         capacity_limit[5:0], written when cfg_wr_en is high    -
//
// One transaction per cycle while the output is not stalled: every cell compares with the new
// value and shifts in the same cycle, and the result sits in one output register stage.
// m_axis_tvalid rises in the cycle after an input is accepted.
// s_axis_tready is high while the output register is empty or being drained.
// Reset empties the store; capacity_limit returns to 32. No clearing pass.
`include "assert_macros.svh"

module sorted_insert_array_top
	import sia_pkg::*;
#(
	parameter int DEPTH = SIA_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CAP_W-1:0]     cfg_wr_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // new_value, read_index
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_value, entry_count, smallest, largest, total
	output logic                 m_axis_tuser   // accepted
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int RDW   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [CAP_W-1:0]          cap_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [DATA_W-1:0]  largest_q;
	logic signed [TOTAL_W-1:0] total_q;

	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  rd_q;
	logic                      ok_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic signed [DATA_W-1:0]  small_q;
	logic signed [DATA_W-1:0]  large_q;
	logic signed [TOTAL_W-1:0] total_out_q;

	logic                      s_fire;
	sia_action_t               action;
	logic signed [DATA_W-1:0]  new_value;
	logic [RIDX_W-1:0]         read_index;
	logic                      full;
	logic                      ins_ok;
	logic                      rd_ok;
	logic signed [DATA_W-1:0]  rd_mux;
	logic                      is_empty;
	logic signed [DATA_W-1:0]  small_cur;
	logic signed [DATA_W-1:0]  large_cur;
	logic signed [DATA_W-1:0]  small_ins;
	logic signed [DATA_W-1:0]  large_ins;
	logic signed [TOTAL_W-1:0] total_ins;
	sia_ins_t                  ins;

	logic signed [DATA_W-1:0]  cell_val [DEPTH];
	logic                      cell_gt  [DEPTH];

	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign action        = sia_action_t'(s_axis_tuser);
	assign new_value     = s_axis_tdata[DATA_W-1:0];
	assign read_index    = s_axis_tdata[DATA_W+RIDX_W-1:DATA_W];

	assign full   = (count_q >= DEPTH_C) || (CMP_W'(count_q) >= CMP_W'(cap_q));
	assign ins_ok = !full;
	assign rd_ok  = RDW'(read_index) < RDW'(count_q);

	assign ins.en    = s_fire && (action == ACT_INSERT) && ins_ok;
	assign ins.value = new_value;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			sia_cell_stat_t stat;
			logic signed [DATA_W-1:0] pv;
			logic pg;

			assign stat.occupied = CNT_W'(gi) < count_q;
			assign stat.tail     = CNT_W'(gi) == count_q;

			if (gi == 0) begin : g_first
				assign pv = '0;
				assign pg = 1'b0;
			end else begin : g_rest
				assign pv = cell_val[gi-1];
				assign pg = cell_gt[gi-1];
			end

			sia_cell u_cell (
				.clk        (clk),
				.ins        (ins),
				.stat       (stat),
				.prev_value (pv),
				.prev_gt    (pg),
				.value      (cell_val[gi]),
				.gt         (cell_gt[gi])
			);
		end
	endgenerate

	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (RDW'(read_index) == RDW'(i)) begin
				rd_mux = rd_mux | cell_val[i];
			end
		end
	end

	assign is_empty  = (count_q == '0);
	assign small_cur = is_empty ? '0 : cell_val[0];
	assign large_cur = is_empty ? '0 : largest_q;
	assign small_ins = (is_empty || (new_value < cell_val[0])) ? new_value : cell_val[0];
	assign large_ins = (is_empty || (new_value > largest_q)) ? new_value : largest_q;
	assign total_ins = total_q + TOTAL_W'(new_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			largest_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (ins.en) begin
				count_q   <= count_q + CNT_W'(1);
				largest_q <= large_ins;
				total_q   <= total_ins;
			end
			if (s_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			if (ins.en) begin
				rd_q        <= '0;
				ok_q        <= 1'b1;
				cnt_q       <= COUNT_W'(count_q + CNT_W'(1));
				small_q     <= small_ins;
				large_q     <= large_ins;
				total_out_q <= total_ins;
			end else begin
				rd_q        <= ((action == ACT_READ) && rd_ok) ? rd_mux : '0;
				ok_q        <= (action == ACT_READ) && rd_ok;
				cnt_q       <= COUNT_W'(count_q);
				small_q     <= small_cur;
				large_q     <= large_cur;
				total_out_q <= total_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = ok_q;
	assign m_axis_tdata  = {5'd0, total_out_q, large_q, small_q, cnt_q, rd_q};

	`ASSERT_CLK(a_count_bound, count_q <= DEPTH_C)
	`ASSERT_NEXT(a_count_step, ins.en, count_q == $past(count_q) + CNT_W'(1))
	`ASSERT_CLK(a_order, (count_q > CNT_W'(1)) |-> (largest_q >= cell_val[0]))
	`ASSERT_NEXT(a_out_load, s_fire, m_axis_tvalid)

endmodule

### hw/rtl/sia_cell.sv
module sia_cell
	import sia_pkg::*;
(
	input  logic                     clk,
	input  sia_ins_t                 ins,
	input  sia_cell_stat_t           stat,
	input  logic signed [DATA_W-1:0] prev_value,
	input  logic                     prev_gt,
	output logic signed [DATA_W-1:0] value,
	output logic                     gt
);

	logic signed [DATA_W-1:0] val_q;

	assign gt    = stat.occupied && (val_q > ins.value);
	assign value = val_q;

	// shift up from the neighbor below, or take the new value at the gap
	always_ff @(posedge clk) begin
		if (ins.en) begin
			if (prev_gt) begin
				val_q <= prev_value;
			end else if (gt || stat.tail) begin
				val_q <= ins.value;
			end
		end
	end

endmodule

### tb/sv/sorted_insert_array_top_tb.sv
module sorted_insert_array_top_tb;
	import sia_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS = 100;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [DATA_W-1:0]  read_value;
		logic               accepted;
		logic [COUNT_W-1:0] entry_count;
		logic [DATA_W-1:0]  smallest;
		logic [DATA_W-1:0]  largest;
		logic [TOTAL_W-1:0] total;
	} sia_result_t;

	class sia_scoreboard;
		logic signed [DATA_W-1:0] entries [SIA_DEPTH];
		int                       n;
		logic [TOTAL_W-1:0]       sum;
		logic [CAP_W-1:0]         limit;
		sia_result_t              due [$];
		int                       errors;

		function new();
			n = 0;
			sum = '0;
			limit = CAP_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [CAP_W-1:0] v);
			limit = v;
		endfunction

		function void note_input(sia_action_t act, logic signed [DATA_W-1:0] v,
				logic [RIDX_W-1:0] idx);
			int          eff;
			int          i;
			sia_result_t r;
			eff = (limit > SIA_DEPTH) ? SIA_DEPTH : int'(limit);
			r.read_value = '0;
			r.accepted = 1'b0;
			if (act == ACT_INSERT) begin
				if (n < eff) begin
					i = n;
					while (i > 0 && entries[i-1] > v) begin
						entries[i] = entries[i-1];
						i--;
					end
					entries[i] = v;
					n++;
					sum = sum + {{(TOTAL_W-DATA_W){v[DATA_W-1]}}, v};
					r.accepted = 1'b1;
				end
			end else if (int'(idx) < n) begin
				r.read_value = entries[idx];
				r.accepted = 1'b1;
			end
			r.entry_count = COUNT_W'(n);
			r.smallest = (n > 0) ? entries[0] : '0;
			r.largest = (n > 0) ? entries[n-1] : '0;
			r.total = sum;
			due.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d, logic u);
			sia_result_t r;
			if (due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
					$time, d, u);
				errors++;
				return;
			end
			r = due.pop_front();
			compare_field("read_value", r.read_value, d[31:0]);
			compare_field("accepted", r.accepted, u);
			compare_field("entry_count", r.entry_count, d[37:32]);
			compare_field("smallest", r.smallest, d[69:38]);
			compare_field("largest", r.largest, d[101:70]);
			compare_field("total", r.total, d[138:102]);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CAP_W-1:0]     cfg_wr_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;   // new_value, read_index
	logic                 s_axis_tuser;   // action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;   // read_value, entry_count, smallest, largest, total
	logic                 m_axis_tuser;   // accepted

	sia_scoreboard sb;
	bit            calm;
	bit            hold_req;
	int            cycles;

	sorted_insert_array_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_insert_array_top_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input sia_action_t act, input logic [DATA_W-1:0] v,
			input logic [RIDX_W-1:0] idx);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, idx, v};
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(act, v, idx);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CAP_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(v);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5: return DATA_W'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int               k;
		int               left;
		int               lim;
		sia_action_t      act;
		logic [RIDX_W-1:0] idx;

		sb = new();
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= ACT_INSERT;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store reads
		send_item(ACT_READ, 32'h0, 5'd0);
		send_item(ACT_READ, 32'hFFFF_FFFF, 5'd31);
		// limit of zero refuses everything
		write_limit(6'd0);
		send_item(ACT_INSERT, 32'd5, 5'd0);
		write_limit(6'd1);
		send_item(ACT_INSERT, 32'h7FFF_FFFF, 5'd0);
		send_item(ACT_INSERT, 32'h8000_0000, 5'd31);
		send_item(ACT_READ, 32'h0, 5'd0);
		send_item(ACT_READ, 32'h0, 5'd1);
		write_limit(6'd33);
		send_item(ACT_INSERT, 32'h8000_0000, 5'd0);
		send_item(ACT_INSERT, 32'h0, 5'd0);
		send_item(ACT_INSERT, 32'h0, 5'd0);
		send_item(ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
		send_item(ACT_INSERT, 32'd7, 5'd0);
		for (k = 0; k < 6; k++)
			send_item(ACT_READ, 32'h0, RIDX_W'(k));
		send_item(ACT_READ, 32'h0, 5'd31);
		// limit below the current count
		write_limit(6'd2);
		send_item(ACT_INSERT, 32'd3, 5'd0);
		send_item(ACT_READ, 32'h0, 5'd5);
		write_limit(6'd32);
		send_item(ACT_INSERT, 32'd1, 5'd0);

		k = 0;
		while (k < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: lim = (sb.n > 0) ? $urandom_range(0, sb.n) : 0;
				1: lim = 63;
				default: lim = sb.n + $urandom_range(1, 4);
			endcase
			if (lim > 63)
				lim = 63;
			if (k >= RANDOM_ITEMS - CALM_ITEMS)
				lim = 63;
			if (!calm)
				write_limit(CAP_W'(lim));
			left = $urandom_range(20, 60);
			if (k < RANDOM_ITEMS - CALM_ITEMS && k + left > RANDOM_ITEMS - CALM_ITEMS)
				left = RANDOM_ITEMS - CALM_ITEMS - k;
			while (left > 0 && k < RANDOM_ITEMS) begin
				if (k >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				if (k == HOLD_AT)
					hold_req = 1'b1;
				act = ($urandom_range(0, 99) < 35) ? ACT_INSERT : ACT_READ;
				if ($urandom_range(0, 3) == 0 || sb.n == 0)
					idx = RIDX_W'($urandom());
				else
					idx = RIDX_W'($urandom_range(0, sb.n - 1));
				send_item(act, pick_value(), idx);
				left--;
				k++;
			end
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("sorted_insert_array_top_tb: PASS");
		else
			$display("sorted_insert_array_top_tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sia_pkg.sv
hw/rtl/sia_cell.sv
hw/rtl/sorted_insert_array_top.sv
tb/sv/sorted_insert_array_top_tb.sv
